### hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FRO_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("framebuffer_raster_ops assertion failed");
`define FRO_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("framebuffer_raster_ops assertion failed");
`else
`define FRO_ASSERT(lbl, clk, rst, prop)
`define FRO_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hw/rtl/fro_pkg.sv
`timescale 1ns / 1ps
package fro_pkg;
   localparam int CANVAS_WIDTH  = 256;
   localparam int CANVAS_HEIGHT = 256;
   localparam int ROW_BYTES     = (CANVAS_WIDTH + 7) / 8;
   localparam int PLANE_BYTES   = ROW_BYTES * CANVAS_HEIGHT;
   localparam int ADDR_W        = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
   localparam int COORD_W       = 12;

   localparam logic [2:0] CMD_PIXEL  = 3'd0;
   localparam logic [2:0] CMD_FILL   = 3'd1;
   localparam logic [2:0] CMD_INVERT = 3'd2;
   localparam logic [2:0] CMD_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;

   localparam logic CSR_ROTATION = 1'b0;
   localparam logic CSR_TWO_BIT  = 1'b1;

   typedef struct packed {
      logic               raw;
      logic [1:0]         rot;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } loc_req_type;
endpackage

### hw/rtl/fro_locate.sv
`timescale 1ns / 1ps
module fro_locate (
   input  logic                        clock,
   input  fro_pkg::loc_req_type        req,
   output logic [fro_pkg::ADDR_W-1:0]  addr,
   output logic [7:0]                  mask
);
   localparam logic [fro_pkg::COORD_W-1:0] W_M1 = fro_pkg::COORD_W'(fro_pkg::CANVAS_WIDTH - 1);
   localparam logic [fro_pkg::COORD_W-1:0] H_M1 = fro_pkg::COORD_W'(fro_pkg::CANVAS_HEIGHT - 1);
   localparam logic [fro_pkg::COORD_W-1:0] RB   = fro_pkg::COORD_W'(fro_pkg::ROW_BYTES);

   logic [fro_pkg::COORD_W-1:0]   bx, by;
   logic [2*fro_pkg::COORD_W-1:0] idx_full;
   logic [fro_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic [7:0]                    mask_ff, mask_in;

   always_comb begin
      bx = req.x;
      by = req.y;
      if (!req.raw) begin
         unique case (req.rot)
            2'd1: begin bx = W_M1 - req.y; by = req.x;        end
            2'd2: begin bx = W_M1 - req.x; by = H_M1 - req.y; end
            2'd3: begin bx = req.y;        by = H_M1 - req.x; end
            default: begin bx = req.x;     by = req.y;        end
         endcase
      end
      idx_full = by * RB + (2*fro_pkg::COORD_W)'(bx >> 3);
      addr_in  = idx_full[fro_pkg::ADDR_W-1:0];
      mask_in  = 8'h80 >> bx[2:0];
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      mask_ff <= mask_in;
   end

   assign addr = addr_ff;
   assign mask = mask_ff;
endmodule

### hw/rtl/fro_ram.sv
`timescale 1ns / 1ps
module fro_ram #(
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = 13
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        wdata,
   output logic [7:0]        rdata
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

### hw/rtl/framebuffer_raster_ops.sv
`timescale 1ns / 1ps
// Bit-plane framebuffer: one command at a time, req_ready is high only in the idle
// state. Pixel, fill and invert step through the address unit, the memory read and
// the read-modify-write for each pixel of the clipped rectangle, then pass to the
// result state. Read-byte steps through the address unit, the memory read, a wait
// state and a capture of the addressed plane byte before the result state.
// Clipped commands and unknown codes go straight from idle to the result state.
// Clear sweeps PLANE_BYTES addresses at one byte per cycle, then enters the result
// state. A write that enters 2 bpp while idle, in a cycle in which no request is
// taken, refills the low plane with 0xFF, and after reset a sweep of PLANE_BYTES
// addresses sets both planes to 0xFF; req_ready stays low during either. Results
// leave through an output register, so a new command can be taken while one waits;
// a finished command whose result finds that register still held stalls in its
// result state until rsp_ready takes the waiting one.
`include "assert_macros.svh"
module framebuffer_raster_ops (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic signed [11:0] req_x_pos,
   input  logic signed [11:0] req_y_pos,
   input  logic signed [11:0] req_rect_width,
   input  logic signed [11:0] req_rect_height,
   input  logic [1:0]  req_color,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_clipped_away,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [1:0]  csr_wdata
);
   localparam int AW = fro_pkg::ADDR_W;
   localparam int CW = fro_pkg::COORD_W;
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOC   = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;
   localparam logic [3:0] S_WR    = 4'd3;
   localparam logic [3:0] S_RDCAP = 4'd4;
   localparam logic [3:0] S_SWEEP = 4'd5;
   localparam logic [3:0] S_RESP  = 4'd6;
   localparam logic [3:0] S_RDWT  = 4'd7;
   localparam logic [AW-1:0] LAST_ADDR = AW'(fro_pkg::PLANE_BYTES - 1);
   localparam logic signed [13:0] CWID = 14'(fro_pkg::CANVAS_WIDTH);
   localparam logic signed [13:0] CHGT = 14'(fro_pkg::CANVAS_HEIGHT);

   logic [3:0]    state_ff, state_in;
   logic [1:0]    rot_ff, rot_in;
   logic          two_ff, two_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [1:0]    color_ff, color_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [AW-1:0] sw_ff, sw_in;
   logic          sw_hi_ff, sw_hi_in, sw_lo_ff, sw_lo_in;
   logic [7:0]    sw_hv_ff, sw_hv_in, sw_lv_ff, sw_lv_in;
   logic          sw_init_ff, sw_init_in;
   logic [7:0]    res_rd_ff, res_rd_in;
   logic          res_clip_ff, res_clip_in;
   logic          ov_ff, ov_in;
   logic [7:0]    od_ff, od_in;
   logic          oc_ff, oc_in;

   fro_pkg::loc_req_type loc_req;
   logic [AW-1:0] loc_addr, hi_addr, lo_addr;
   logic [7:0]    loc_mask, hi_rd, lo_rd, hi_wd, lo_wd;
   logic          hi_we, lo_we, accept, on_hi;
   logic signed [13:0] xs, ys, x0s, y0s, x1s, y1s, lw, lh, wv, hv;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign loc_req.raw = (cmd_ff == fro_pkg::CMD_READ);
   assign loc_req.rot = rot_ff;
   assign loc_req.x   = i_ff;
   assign loc_req.y   = j_ff;

   fro_locate u_locate (
      .clock (clock),
      .req   (loc_req),
      .addr  (loc_addr),
      .mask  (loc_mask)
   );

   fro_ram #(.DEPTH(fro_pkg::PLANE_BYTES), .ADDR_W(AW)) u_plane_high (
      .clock (clock), .we (hi_we), .addr (hi_addr), .wdata (hi_wd), .rdata (hi_rd)
   );

   fro_ram #(.DEPTH(fro_pkg::PLANE_BYTES), .ADDR_W(AW)) u_plane_low (
      .clock (clock), .we (lo_we), .addr (lo_addr), .wdata (lo_wd), .rdata (lo_rd)
   );

   always_comb begin
      xs  = 14'(req_x_pos);
      ys  = 14'(req_y_pos);
      lw  = rot_ff[0] ? CHGT : CWID;
      lh  = rot_ff[0] ? CWID : CHGT;
      wv  = (req_command == fro_pkg::CMD_PIXEL) ? 14'sd1 : 14'(req_rect_width);
      hv  = (req_command == fro_pkg::CMD_PIXEL) ? 14'sd1 : 14'(req_rect_height);
      x0s = (xs < 0) ? 14'sd0 : xs;
      y0s = (ys < 0) ? 14'sd0 : ys;
      x1s = (xs + wv > lw) ? lw : xs + wv;
      y1s = (ys + hv > lh) ? lh : ys + hv;
      on_hi = two_ff ? color_ff[1] : (color_ff != 2'd0);
   end

   always_comb begin
      hi_we = 1'b0;
      lo_we = 1'b0;
      hi_addr = loc_addr;
      lo_addr = loc_addr;
      hi_wd = on_hi ? (hi_rd | loc_mask) : (hi_rd & ~loc_mask);
      lo_wd = color_ff[0] ? (lo_rd | loc_mask) : (lo_rd & ~loc_mask);
      if (cmd_ff == fro_pkg::CMD_INVERT) begin
         hi_wd = hi_rd ^ loc_mask;
      end
      if (state_ff == S_WR) begin
         hi_we = 1'b1;
         lo_we = two_ff && (cmd_ff != fro_pkg::CMD_INVERT);
      end else if (state_ff == S_SWEEP) begin
         hi_addr = sw_ff;
         lo_addr = sw_ff;
         hi_wd = sw_hv_ff;
         lo_wd = sw_lv_ff;
         hi_we = sw_hi_ff;
         lo_we = sw_lo_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      rot_in = rot_ff;
      two_in = two_ff;
      cmd_in = cmd_ff;
      color_in = color_ff;
      i_in = i_ff; j_in = j_ff; x0_in = x0_ff; x1_in = x1_ff; y1_in = y1_ff;
      sw_in = sw_ff; sw_hi_in = sw_hi_ff; sw_lo_in = sw_lo_ff;
      sw_hv_in = sw_hv_ff; sw_lv_in = sw_lv_ff;
      res_rd_in = res_rd_ff; res_clip_in = res_clip_ff;
      ov_in = ov_ff; od_in = od_ff; oc_in = oc_ff;

      if (ov_ff && rsp_ready) begin
         ov_in = 1'b0;
      end

      if (csr_we) begin
         if (csr_index == fro_pkg::CSR_ROTATION) begin
            rot_in = csr_wdata;
         end else begin
            two_in = csr_wdata[0];
            if (csr_wdata[0] && !two_ff && state_ff == S_IDLE) begin
               state_in = S_SWEEP;
               sw_in = '0;
               sw_hi_in = 1'b0;
               sw_lo_in = 1'b1;
               sw_lv_in = 8'hFF;
            end
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_command;
               color_in = req_color;
               res_rd_in = 8'h00;
               res_clip_in = 1'b0;
               state_in = S_RESP;
               unique case (req_command)
                  fro_pkg::CMD_PIXEL, fro_pkg::CMD_FILL, fro_pkg::CMD_INVERT: begin
                     x0_in = CW'(x0s);
                     i_in  = CW'(x0s);
                     j_in  = CW'(y0s);
                     x1_in = CW'(x1s);
                     y1_in = CW'(y1s);
                     if (x0s >= x1s || y0s >= y1s) begin
                        res_clip_in = 1'b1;
                     end else begin
                        state_in = S_LOC;
                     end
                  end
                  fro_pkg::CMD_CLEAR: begin
                     state_in = S_SWEEP;
                     sw_in = '0;
                     sw_hi_in = 1'b1;
                     sw_lo_in = two_ff;
                     sw_hv_in = (two_ff ? req_color[1] : (req_color != 2'd0)) ? 8'hFF : 8'h00;
                     sw_lv_in = req_color[0] ? 8'hFF : 8'h00;
                  end
                  fro_pkg::CMD_READ: begin
                     i_in = req_x_pos;
                     j_in = req_y_pos;
                     if (xs < 0 || ys < 0 || (xs >>> 3) >= 14'(fro_pkg::ROW_BYTES)
                         || ys >= CHGT) begin
                        res_clip_in = 1'b1;
                     end else begin
                        state_in = S_LOC;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_LOC: state_in = S_RD;
         S_RD: state_in = (cmd_ff == fro_pkg::CMD_READ) ? S_RDWT : S_WR;
         S_RDWT: state_in = S_RDCAP;
         S_RDCAP: begin
            res_rd_in = color_ff[0] ? lo_rd : hi_rd;
            state_in = S_RESP;
         end
         S_WR: begin
            if (i_ff + 1'b1 == x1_ff) begin
               i_in = x0_ff;
               if (j_ff + 1'b1 == y1_ff) begin
                  state_in = S_RESP;
               end else begin
                  j_in = j_ff + 1'b1;
                  state_in = S_LOC;
               end
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_LOC;
            end
         end
         S_SWEEP: begin
            sw_in = sw_ff + 1'b1;
            if (sw_ff == LAST_ADDR) begin
               state_in = (sw_hi_ff && cmd_ff == fro_pkg::CMD_CLEAR && !sw_init_ff)
                          ? S_RESP : S_IDLE;
            end
         end
         S_RESP: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               od_in = res_rd_ff;
               oc_in = res_clip_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      sw_init_in = sw_init_ff;
      if (state_ff == S_SWEEP && sw_ff == LAST_ADDR) begin
         sw_init_in = 1'b0;
      end
      if (state_ff == S_IDLE && csr_we) begin
         sw_init_in = 1'b1;
      end
      if (accept) begin
         sw_init_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         rot_ff <= 2'd0;
         two_ff <= 1'b0;
         cmd_ff <= fro_pkg::CMD_PIXEL;
         sw_ff <= '0;
         sw_hi_ff <= 1'b1;
         sw_lo_ff <= 1'b1;
         sw_hv_ff <= 8'hFF;
         sw_lv_ff <= 8'hFF;
         sw_init_ff <= 1'b1;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rot_ff <= rot_in;
         two_ff <= two_in;
         cmd_ff <= cmd_in;
         sw_ff <= sw_in;
         sw_hi_ff <= sw_hi_in;
         sw_lo_ff <= sw_lo_in;
         sw_hv_ff <= sw_hv_in;
         sw_lv_ff <= sw_lv_in;
         sw_init_ff <= sw_init_in;
         ov_ff <= ov_in;
      end
      color_ff <= color_in;
      i_ff <= i_in; j_ff <= j_in; x0_ff <= x0_in; x1_ff <= x1_in; y1_ff <= y1_in;
      res_rd_ff <= res_rd_in;
      res_clip_ff <= res_clip_in;
      od_ff <= od_in;
      oc_ff <= oc_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_read_data = od_ff;
   assign rsp_clipped_away = oc_ff;

   `FRO_ASSERT(a_clip_no_data, clock, reset, (ov_ff && oc_ff) |-> (od_ff == 8'h00))
   `FRO_ASSERT(a_we_states, clock, reset, (hi_we || lo_we) |-> (state_ff == S_WR || state_ff == S_SWEEP))
   `FRO_ASSERT(a_low_inv, clock, reset, (state_ff == S_WR && cmd_ff == fro_pkg::CMD_INVERT) |-> !lo_we)
endmodule

### tb/sv/framebuffer_raster_ops_checker.sv
`timescale 1ns / 1ps
module framebuffer_raster_ops_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [2:0]        req_command,
   input  logic signed [11:0] req_x_pos,
   input  logic signed [11:0] req_y_pos,
   input  logic signed [11:0] req_rect_width,
   input  logic signed [11:0] req_rect_height,
   input  logic [1:0]        req_color,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [7:0]        rsp_read_data,
   input  logic              rsp_clipped_away,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [1:0]        csr_wdata,
   output int                fail_count,
   output int                pending
);
   typedef struct {
      logic [7:0] read_data;
      logic       clipped;
   } outcome_type;

   logic [7:0]  hi_plane [fro_pkg::PLANE_BYTES];
   logic [7:0]  lo_plane [fro_pkg::PLANE_BYTES];
   logic [1:0]  cur_rot;
   logic        cur_two_bit;
   outcome_type outcome_q[$];

   function automatic int logical_w();
      return cur_rot[0] ? fro_pkg::CANVAS_HEIGHT : fro_pkg::CANVAS_WIDTH;
   endfunction

   function automatic int logical_h();
      return cur_rot[0] ? fro_pkg::CANVAS_WIDTH : fro_pkg::CANVAS_HEIGHT;
   endfunction

   function automatic void pixel_addr(input int x, input int y, output int idx,
                                      output logic [7:0] mask);
      int bx, by;
      case (cur_rot)
         2'd1: begin
            bx = fro_pkg::CANVAS_WIDTH - 1 - y; by = x;
         end
         2'd2: begin
            bx = fro_pkg::CANVAS_WIDTH - 1 - x; by = fro_pkg::CANVAS_HEIGHT - 1 - y;
         end
         2'd3: begin
            bx = y; by = fro_pkg::CANVAS_HEIGHT - 1 - x;
         end
         default: begin bx = x; by = y; end
      endcase
      idx  = (by * fro_pkg::ROW_BYTES + (bx >> 3)) % fro_pkg::PLANE_BYTES;
      mask = 8'h80 >> (bx & 7);
   endfunction

   function automatic void draw_pixel(input int x, input int y, input logic [1:0] c);
      int idx;
      logic [7:0] mask;
      pixel_addr(x, y, idx, mask);
      if (cur_two_bit) begin
         hi_plane[idx] = c[1] ? (hi_plane[idx] | mask) : (hi_plane[idx] & ~mask);
         lo_plane[idx] = c[0] ? (lo_plane[idx] | mask) : (lo_plane[idx] & ~mask);
      end else begin
         hi_plane[idx] = (c != 0) ? (hi_plane[idx] | mask) : (hi_plane[idx] & ~mask);
      end
   endfunction

   function automatic outcome_type run_command(input logic [2:0] cmd, input int x,
                                               input int y, input int w, input int h,
                                               input logic [1:0] c);
      outcome_type o;
      int x0, y0, x1, y1, idx;
      logic [7:0] mask;
      o.read_data = 8'h00;
      o.clipped   = 1'b0;
      case (cmd)
         fro_pkg::CMD_PIXEL: begin
            if (x < 0 || x >= logical_w() || y < 0 || y >= logical_h()) o.clipped = 1'b1;
            else draw_pixel(x, y, c);
         end
         fro_pkg::CMD_FILL, fro_pkg::CMD_INVERT: begin
            x0 = (x < 0) ? 0 : x;
            y0 = (y < 0) ? 0 : y;
            x1 = x + w;
            y1 = y + h;
            if (x1 > logical_w()) x1 = logical_w();
            if (y1 > logical_h()) y1 = logical_h();
            if (x0 >= x1 || y0 >= y1) begin
               o.clipped = 1'b1;
            end else begin
               for (int j = y0; j < y1; j++) begin
                  for (int i = x0; i < x1; i++) begin
                     if (cmd == fro_pkg::CMD_FILL) begin
                        draw_pixel(i, j, c);
                     end else begin
                        pixel_addr(i, j, idx, mask);
                        hi_plane[idx] = hi_plane[idx] ^ mask;
                     end
                  end
               end
            end
         end
         fro_pkg::CMD_CLEAR: begin
            for (int k = 0; k < fro_pkg::PLANE_BYTES; k++) begin
               if (cur_two_bit) begin
                  hi_plane[k] = c[1] ? 8'hFF : 8'h00;
                  lo_plane[k] = c[0] ? 8'hFF : 8'h00;
               end else begin
                  hi_plane[k] = (c != 0) ? 8'hFF : 8'h00;
               end
            end
         end
         fro_pkg::CMD_READ: begin
            if (x < 0 || y < 0 || (x >> 3) >= fro_pkg::ROW_BYTES
                || y >= fro_pkg::CANVAS_HEIGHT) begin
               o.clipped = 1'b1;
            end else begin
               idx = (y * fro_pkg::ROW_BYTES + (x >> 3)) % fro_pkg::PLANE_BYTES;
               o.read_data = c[0] ? lo_plane[idx] : hi_plane[idx];
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         for (int k = 0; k < fro_pkg::PLANE_BYTES; k++) begin
            hi_plane[k] = 8'hFF;
            lo_plane[k] = 8'hFF;
         end
         cur_rot     = 2'd0;
         cur_two_bit = 1'b0;
         outcome_q.delete();
         fail_count  = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == fro_pkg::CSR_ROTATION) begin
               cur_rot = csr_wdata;
            end else begin
               if (csr_wdata[0] && !cur_two_bit)
                  for (int k = 0; k < fro_pkg::PLANE_BYTES; k++) lo_plane[k] = 8'hFF;
               cur_two_bit = csr_wdata[0];
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: result transfer with none expected: data %h clip %b",
                        $time, rsp_read_data, rsp_clipped_away);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h actual %h", $time,
                           want.read_data, rsp_read_data);
                  fail_count++;
               end
               if (rsp_clipped_away !== want.clipped) begin
                  $display("%0t: clipped_away expected %b actual %b", $time,
                           want.clipped, rsp_clipped_away);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            got = run_command(req_command, req_x_pos, req_y_pos,
                              req_rect_width, req_rect_height, req_color);
            outcome_q = {outcome_q, got};
         end
      end
      pending = outcome_q.size();
   end
endmodule

### tb/sv/framebuffer_raster_ops_tb.sv
`timescale 1ns / 1ps
module framebuffer_raster_ops_tb;
   localparam int CYCLE_LIMIT = 8000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [2:0]        req_command = fro_pkg::CMD_PIXEL;
   logic signed [11:0] req_x_pos = '0;
   logic signed [11:0] req_y_pos = '0;
   logic signed [11:0] req_rect_width = '0;
   logic signed [11:0] req_rect_height = '0;
   logic [1:0]        req_color = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [7:0]        rsp_read_data;
   logic              rsp_clipped_away;
   logic              csr_we = 1'b0;
   logic              csr_index = fro_pkg::CSR_ROTATION;
   logic [1:0]        csr_wdata = '0;

   int fail_count;
   int pending;
   int send_idle = 34;
   int recv_idle = 48;
   int cycle_count = 0;
   int rot = 0;
   int lcx, lcy, bcx, bcy;
   int wait_count;

   framebuffer_raster_ops DUT (.*);
   framebuffer_raster_ops_checker checker_inst (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("framebuffer_raster_ops test failed");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle);

   task automatic send(input logic [2:0] cmd, input int x, input int y, input int w,
                       input int h, input logic [1:0] c);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_x_pos       <= 12'(x);
      req_y_pos       <= 12'(y);
      req_rect_width  <= 12'(w);
      req_rect_height <= 12'(h);
      req_color       <= c;
      @(posedge clock iff req_ready);
   endtask

   task automatic write_csr(input logic idx, input logic [1:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == fro_pkg::CSR_ROTATION) rot = int'(val);
   endtask

   task automatic pick_center();
      int lw, lh;
      lw  = rot[0] ? fro_pkg::CANVAS_HEIGHT : fro_pkg::CANVAS_WIDTH;
      lh  = rot[0] ? fro_pkg::CANVAS_WIDTH : fro_pkg::CANVAS_HEIGHT;
      lcx = $urandom_range(lw - 1);
      lcy = $urandom_range(lh - 1);
      case (rot)
         1: begin
            bcx = fro_pkg::CANVAS_WIDTH - 1 - lcy; bcy = lcx;
         end
         2: begin
            bcx = fro_pkg::CANVAS_WIDTH - 1 - lcx; bcy = fro_pkg::CANVAS_HEIGHT - 1 - lcy;
         end
         3: begin
            bcx = lcy; bcy = fro_pkg::CANVAS_HEIGHT - 1 - lcx;
         end
         default: begin bcx = lcx; bcy = lcy; end
      endcase
   endtask

   function automatic int near(input int c, input int span);
      return c - span + $signed($urandom_range(2 * span));
   endfunction

   task automatic random_item();
      int r, sel, x, y, w, h;
      logic [2:0] cmd;
      logic [11:0] raw;
      r   = $urandom_range(99);
      sel = $urandom_range(9);
      x   = near(lcx, 12);
      y   = near(lcy, 12);
      w   = $signed($urandom_range(18)) - 2;
      h   = $signed($urandom_range(10)) - 2;
      if ($urandom_range(199) == 0) begin
         cmd = fro_pkg::CMD_CLEAR;
      end else if (r < 32) begin
         cmd = fro_pkg::CMD_READ;
         x = near(bcx, 16);
         y = near(bcy, 8);
         if (sel == 0) begin
            raw = 12'($urandom); x = $signed(raw);
            raw = 12'($urandom); y = $signed(raw);
         end else if (sel == 1) begin
            x = $urandom_range(263) - 4;
            y = $urandom_range(263) - 4;
         end
      end else if (r < 60) begin
         cmd = fro_pkg::CMD_PIXEL;
         if (sel == 0) begin
            raw = 12'($urandom); x = $signed(raw);
            raw = 12'($urandom); y = $signed(raw);
         end
      end else if (r < 90) begin
         cmd = (r < 80) ? fro_pkg::CMD_FILL : fro_pkg::CMD_INVERT;
         if (sel == 0) begin
            raw = 12'($urandom); w = $signed(raw);
            h = $urandom_range(3);
            raw = 12'($urandom); x = $signed(raw);
         end else if (sel == 1) begin
            raw = 12'($urandom); h = $signed(raw);
            w = $urandom_range(3);
            raw = 12'($urandom); y = $signed(raw);
         end
      end else begin
         cmd = 3'($urandom_range(7, 5));
         raw = 12'($urandom); x = $signed(raw);
         raw = 12'($urandom); y = $signed(raw);
         raw = 12'($urandom); w = $signed(raw);
         raw = 12'($urandom); h = $signed(raw);
      end
      send(cmd, x, y, w, h, 2'($urandom_range(3)));
   endtask

   initial begin
      logic [1:0] rot_seq [9]  = '{0, 1, 2, 3, 0, 3, 1, 2, 0};
      logic       mode_seq [9] = '{0, 0, 1, 1, 1, 0, 1, 0, 0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(fro_pkg::CMD_READ, 0, 0, 0, 0, 0);
      send(fro_pkg::CMD_PIXEL, 0, 0, 0, 0, 0);
      send(fro_pkg::CMD_PIXEL, 255, 255, 0, 0, 0);
      send(fro_pkg::CMD_PIXEL, -1, 0, 0, 0, 1);
      send(fro_pkg::CMD_PIXEL, 0, 256, 0, 0, 1);
      send(fro_pkg::CMD_PIXEL, -2048, 2047, 0, 0, 3);
      send(fro_pkg::CMD_READ, 0, 0, 0, 0, 0);
      send(fro_pkg::CMD_READ, 255, 255, 0, 0, 2);
      send(fro_pkg::CMD_FILL, -2048, 3, 2047, 1, 0);
      send(fro_pkg::CMD_FILL, 10, 10, 0, 5, 0);
      send(fro_pkg::CMD_FILL, 10, 10, -2048, -2048, 0);
      send(fro_pkg::CMD_FILL, 2047, 2047, 4, 4, 0);
      send(fro_pkg::CMD_INVERT, 0, 0, 2047, 2047, 0);
      send(fro_pkg::CMD_INVERT, 3, 5, 13, 3, 2);
      send(fro_pkg::CMD_READ, 8, 5, 0, 0, 0);
      send(fro_pkg::CMD_READ, 256, 0, 0, 0, 0);
      send(fro_pkg::CMD_READ, 0, -1, 0, 0, 0);
      send(fro_pkg::CMD_READ, 2047, -2048, 0, 0, 3);
      send(fro_pkg::CMD_READ, 0, 3, 0, 0, 1);
      send(fro_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
      send(fro_pkg::CMD_READ, 100, 100, 0, 0, 0);
      send(fro_pkg::CMD_CLEAR, 0, 0, 0, 0, 3);
      send(3'd7, -1, -1, -1, -1, 3);
      send(3'd5, 0, 0, 0, 0, 0);

      for (int p = 0; p < 9; p++) begin
         write_csr(fro_pkg::CSR_ROTATION, rot_seq[p]);
         write_csr(fro_pkg::CSR_TWO_BIT, {1'b0, mode_seq[p]});
         send_idle = (p < 3) ? 34 : (p < 6) ? 48 : 0;
         recv_idle = (p < 3) ? 48 : (p < 6) ? 34 : 0;
         for (int n = 0; n < 185; n++) begin
            if (n % 40 == 0) pick_center();
            random_item();
         end
         req_valid <= 1'b0;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait_count = 0;
      while (pending != 0 && wait_count < 2000000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("framebuffer_raster_ops test passed");
      end else begin
         $display("framebuffer_raster_ops test failed");
      end
      $finish;
   end
endmodule

### framebuffer_raster_ops.f
+incdir+hw/rtl
hw/rtl/fro_pkg.sv
hw/rtl/fro_locate.sv
hw/rtl/fro_ram.sv
hw/rtl/framebuffer_raster_ops.sv
tb/sv/framebuffer_raster_ops_checker.sv
tb/sv/framebuffer_raster_ops_tb.sv
